/* rtl/lsps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared constants, codes and types of the limit switch position servo.
// ----------------------------------------------------------------------------
package lsps_pkg;

   // encoder span between the two end switches
   localparam int unsigned LOW_END_COUNT  = 29720;
   localparam int unsigned HIGH_END_COUNT = 30000;
   localparam int unsigned SPAN           = HIGH_END_COUNT - LOW_END_COUNT;

   // target scale: 0 and TARGET_FULL seek an end switch
   localparam int unsigned TARGET_FULL = 250;
   localparam int unsigned TARGET_W    = 8;

   // field widths
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned DRIVE_W  = 10;
   localparam int unsigned DBAND_W  = 8;
   localparam int unsigned STATUS_W = 2;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] REG_DEADBAND   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_DRIVE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_DRIVE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SEEK_DRIVE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_HIGH  = 3'd4;

   localparam logic [DBAND_W-1:0] DEADBAND_RESET   = 8'd5;
   localparam logic [DRIVE_W-1:0] MIN_DRIVE_RESET  = 10'd500;
   localparam logic [DRIVE_W-1:0] MAX_DRIVE_RESET  = 10'd1000;
   localparam logic [DRIVE_W-1:0] SEEK_DRIVE_RESET = 10'd700;

   // target offset = t * SPAN / TARGET_FULL, split into whole and remainder parts
   localparam int unsigned OFF_W      = $clog2(SPAN + 1);
   localparam int unsigned SPAN_WHOLE = SPAN / TARGET_FULL;
   localparam int unsigned SPAN_REM   = SPAN % TARGET_FULL;
   localparam int unsigned REM_W      = $clog2(255 * (TARGET_FULL - 1) + 1);
   localparam int unsigned FRAC_SHIFT = 24;
   localparam int unsigned FRAC_RECIP = (2**FRAC_SHIFT + TARGET_FULL - 1) / TARGET_FULL;
   localparam int unsigned FRAC_PROD_W = FRAC_SHIFT + OFF_W;

   // target and error widths
   localparam int unsigned TGT_W = COUNT_W + 1;
   localparam int unsigned ERR_W = COUNT_W + 2;

   // proportional drive: mag * |max - min| / SPAN by reciprocal
   localparam int unsigned PROD_W     = OFF_W + DRIVE_W;
   localparam int unsigned DIV_SHIFT  = 28;
   localparam int unsigned DIV_RECIP  = (2**DIV_SHIFT + SPAN - 1) / SPAN;
   localparam int unsigned DIV_PROD_W = DIV_SHIFT + DRIVE_W;

   // motor command codes
   localparam int unsigned CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_STOP      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UP        = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DOWN      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD_HIGH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOAD_LOW  = 3'd4;

   // motion status codes
   localparam logic [STATUS_W-1:0] STATUS_STOP = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UP   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DOWN = 2'd2;

   // cycles from accept to result strobe
   localparam int unsigned LATENCY = 8;

   // switch and seek flags carried along the front stages
   typedef struct packed {
      logic seek;
      logic seek_high;
      logic low_sw;
      logic high_sw;
   } flags_type;

   // decision handed to the drive stages
   typedef struct packed {
      logic             valid;
      logic [CMD_W-1:0] cmd;
      logic             seek;
      logic             sat;
      logic [OFF_W-1:0] mag;
   } dec_type;

endpackage

/* rtl/lsps_drive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_drive
// Proportional drive (product, reciprocal divide) and result formatting.
// ----------------------------------------------------------------------------
module lsps_drive (
   input  logic                             clock,
   input  logic                             reset,
   input  lsps_pkg::dec_type                dec,
   input  logic [lsps_pkg::DRIVE_W-1:0]     min_drive,
   input  logic [lsps_pkg::DRIVE_W-1:0]     max_drive,
   input  logic [lsps_pkg::DRIVE_W-1:0]     seek_drive,
   output logic                             rsp_strobe,
   output logic [lsps_pkg::DRIVE_W-1:0]     rsp_drive_up,
   output logic [lsps_pkg::DRIVE_W-1:0]     rsp_drive_down,
   output logic                             rsp_reload_counter,
   output logic [lsps_pkg::COUNT_W-1:0]     rsp_reload_value,
   output logic [lsps_pkg::STATUS_W-1:0]    rsp_motion_status
);

   logic                                ascend;
   logic [lsps_pkg::DRIVE_W-1:0]        diff_abs;

   lsps_pkg::dec_type                   ctl1_ff, ctl2_ff;
   logic [lsps_pkg::PROD_W-1:0]         prod_in, prod_ff;
   logic [lsps_pkg::DIV_PROD_W-1:0]     recip_prod;
   logic [lsps_pkg::DRIVE_W-1:0]        quot_in, quot_ff;
   logic [lsps_pkg::DRIVE_W-1:0]        drive;

   logic                                strobe_in, strobe_ff;
   logic [lsps_pkg::DRIVE_W-1:0]        up_in, up_ff, down_in, down_ff;
   logic                                reload_in, reload_ff;
   logic [lsps_pkg::COUNT_W-1:0]        rval_in, rval_ff;
   logic [lsps_pkg::STATUS_W-1:0]       status_in, status_ff;

   assign ascend   = (max_drive >= min_drive);
   assign diff_abs = ascend ? (max_drive - min_drive) : (min_drive - max_drive);

   // stage 1: error magnitude times drive range
   assign prod_in = lsps_pkg::PROD_W'(dec.mag) * lsps_pkg::PROD_W'(diff_abs);

   // stage 2: divide by the span through its reciprocal
   assign recip_prod = lsps_pkg::DIV_PROD_W'(prod_ff)
                     * lsps_pkg::DIV_PROD_W'(lsps_pkg::DIV_RECIP);
   assign quot_in    = recip_prod[lsps_pkg::DIV_PROD_W-1:lsps_pkg::DIV_SHIFT];

   // stage 3: final drive and result fields
   always_comb begin
      if (ctl2_ff.sat) begin
         drive = max_drive;
      end else if (ascend) begin
         drive = min_drive + quot_ff;
      end else begin
         drive = min_drive - quot_ff;
      end
      strobe_in = ctl2_ff.valid;
      up_in     = '0;
      down_in   = '0;
      reload_in = 1'b0;
      rval_in   = '0;
      status_in = lsps_pkg::STATUS_STOP;
      case (ctl2_ff.cmd)
         lsps_pkg::CMD_UP: begin
            up_in     = ctl2_ff.seek ? seek_drive : drive;
            status_in = lsps_pkg::STATUS_UP;
         end
         lsps_pkg::CMD_DOWN: begin
            down_in   = ctl2_ff.seek ? seek_drive : drive;
            status_in = lsps_pkg::STATUS_DOWN;
         end
         lsps_pkg::CMD_LOAD_HIGH: begin
            reload_in = 1'b1;
            rval_in   = lsps_pkg::COUNT_W'(lsps_pkg::HIGH_END_COUNT);
         end
         lsps_pkg::CMD_LOAD_LOW: begin
            reload_in = 1'b1;
            rval_in   = lsps_pkg::COUNT_W'(lsps_pkg::LOW_END_COUNT);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff   <= '0;
         ctl2_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ctl1_ff   <= dec;
         ctl2_ff   <= ctl1_ff;
         strobe_ff <= strobe_in;
      end
      prod_ff   <= prod_in;
      quot_ff   <= quot_in;
      up_ff     <= up_in;
      down_ff   <= down_in;
      reload_ff <= reload_in;
      rval_ff   <= rval_in;
      status_ff <= status_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_drive_up       = up_ff;
   assign rsp_drive_down     = down_ff;
   assign rsp_reload_counter = reload_ff;
   assign rsp_reload_value   = rval_ff;
   assign rsp_motion_status  = status_ff;

   // a proportional drive never leaves the span between min and max
   a_drive_bounded: assert property (@(posedge clock) disable iff (reset)
      (ctl2_ff.valid && !ctl2_ff.sat && ascend) |-> (drive <= max_drive))
      else $error("proportional drive above max");

   // the drive stages only ever carry what the decision stage handed in
   a_ctl_follows: assert property (@(posedge clock) disable iff (reset)
      ctl2_ff.valid |-> $past(dec.valid, 2))
      else $error("drive stage item without decision");

   // a reload always carries one of the two end counts
   a_reload_value: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && reload_ff) |->
         (rval_ff == lsps_pkg::COUNT_W'(lsps_pkg::HIGH_END_COUNT) ||
          rval_ff == lsps_pkg::COUNT_W'(lsps_pkg::LOW_END_COUNT)))
      else $error("reload value is not an end count");

endmodule

/* rtl/limit_switch_position_servo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_switch_position_servo
// Position servo with end switches, seek-to-end targets and a deadband.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  request  | start, busy, req_*                      | accepted when start & !busy
//  response | rsp_strobe, rsp_*                       | one strobe per item, no stall
//  csr      | csr_we, csr_index, csr_wdata            | write when csr_we high
//
//  one item per clock; busy stays low, the pipeline never holds an item back
//  each item's result strobes after the 8 register stages: input capture,
//  offset product, reciprocal divide, error, decision, drive product,
//  reciprocal divide by the span and the output register
//  synchronous reset clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module limit_switch_position_servo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lsps_pkg::TARGET_W-1:0]     req_target_position,
   input  logic [lsps_pkg::COUNT_W-1:0]      req_encoder_count,
   input  logic                              req_low_switch_pressed,
   input  logic                              req_high_switch_pressed,
   output logic                              rsp_strobe,
   output logic [lsps_pkg::DRIVE_W-1:0]      rsp_drive_up,
   output logic [lsps_pkg::DRIVE_W-1:0]      rsp_drive_down,
   output logic                              rsp_reload_counter,
   output logic [lsps_pkg::COUNT_W-1:0]      rsp_reload_value,
   output logic [lsps_pkg::STATUS_W-1:0]     rsp_motion_status,
   input  logic                              csr_we,
   input  logic [lsps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lsps_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration registers
   logic [lsps_pkg::DBAND_W-1:0]  deadband_in, deadband_ff;
   logic [lsps_pkg::DRIVE_W-1:0]  min_drive_in, min_drive_ff;
   logic [lsps_pkg::DRIVE_W-1:0]  max_drive_in, max_drive_ff;
   logic [lsps_pkg::DRIVE_W-1:0]  seek_drive_in, seek_drive_ff;
   logic                          zero_high_in, zero_high_ff;

   logic                          req_accept;

   // stage 1: captured item
   logic                          v1_ff;
   logic [lsps_pkg::TARGET_W-1:0] t1_in, t1_ff;
   logic [lsps_pkg::COUNT_W-1:0]  cnt1_ff;
   logic                          lsw1_ff, hsw1_ff;

   // stage 2: seek flags and offset partial products
   logic                          v2_ff;
   lsps_pkg::flags_type           fl2_in, fl2_ff;
   logic [lsps_pkg::OFF_W-1:0]    whole2_in, whole2_ff;
   logic [lsps_pkg::REM_W-1:0]    rem2_in, rem2_ff;
   logic [lsps_pkg::COUNT_W-1:0]  cnt2_ff;

   // stage 3: offset from the start end
   logic                          v3_ff;
   lsps_pkg::flags_type           fl3_ff;
   logic [lsps_pkg::FRAC_PROD_W-1:0] frac_prod;
   logic [lsps_pkg::OFF_W-1:0]    off3_in, off3_ff;
   logic [lsps_pkg::COUNT_W-1:0]  cnt3_ff;

   // stage 4: position error
   logic                          v4_ff;
   lsps_pkg::flags_type           fl4_ff;
   logic [lsps_pkg::TGT_W-1:0]    target;
   logic signed [lsps_pkg::ERR_W-1:0] err4_in, err4_ff;

   // stage 5: decision
   logic signed [lsps_pkg::ERR_W-1:0] dband_s;
   logic                          move_up, move_down;
   logic signed [lsps_pkg::ERR_W-1:0] err_abs;
   logic [lsps_pkg::COUNT_W-1:0]  mag;
   lsps_pkg::dec_type             dec_in, dec_ff;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   // register write decode
   always_comb begin
      deadband_in   = deadband_ff;
      min_drive_in  = min_drive_ff;
      max_drive_in  = max_drive_ff;
      seek_drive_in = seek_drive_ff;
      zero_high_in  = zero_high_ff;
      if (csr_we) begin
         unique case (csr_index)
            lsps_pkg::REG_DEADBAND:   deadband_in   = csr_wdata[lsps_pkg::DBAND_W-1:0];
            lsps_pkg::REG_MIN_DRIVE:  min_drive_in  = csr_wdata[lsps_pkg::DRIVE_W-1:0];
            lsps_pkg::REG_MAX_DRIVE:  max_drive_in  = csr_wdata[lsps_pkg::DRIVE_W-1:0];
            lsps_pkg::REG_SEEK_DRIVE: seek_drive_in = csr_wdata[lsps_pkg::DRIVE_W-1:0];
            lsps_pkg::REG_ZERO_HIGH:  zero_high_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // stage 1: targets above full scale count as full scale
   assign t1_in = (req_target_position > lsps_pkg::TARGET_W'(lsps_pkg::TARGET_FULL)) ?
                  lsps_pkg::TARGET_W'(lsps_pkg::TARGET_FULL) : req_target_position;

   // stage 2
   always_comb begin
      fl2_in.seek      = (t1_ff == '0) ||
                         (t1_ff == lsps_pkg::TARGET_W'(lsps_pkg::TARGET_FULL));
      fl2_in.seek_high = (t1_ff == '0) ? zero_high_ff : !zero_high_ff;
      fl2_in.low_sw    = lsw1_ff;
      fl2_in.high_sw   = hsw1_ff;
   end
   assign whole2_in = lsps_pkg::OFF_W'(t1_ff * lsps_pkg::SPAN_WHOLE);
   assign rem2_in   = lsps_pkg::REM_W'(t1_ff * lsps_pkg::SPAN_REM);

   // stage 3: remainder part divided by full scale through its reciprocal
   assign frac_prod = lsps_pkg::FRAC_PROD_W'(rem2_ff)
                    * lsps_pkg::FRAC_PROD_W'(lsps_pkg::FRAC_RECIP);
   assign off3_in   = whole2_ff
                    + frac_prod[lsps_pkg::FRAC_PROD_W-1:lsps_pkg::FRAC_SHIFT];

   // stage 4
   assign target  = zero_high_ff ?
                    (lsps_pkg::TGT_W'(lsps_pkg::HIGH_END_COUNT) - lsps_pkg::TGT_W'(off3_ff)) :
                    (lsps_pkg::TGT_W'(lsps_pkg::LOW_END_COUNT) + lsps_pkg::TGT_W'(off3_ff));
   assign err4_in = $signed(lsps_pkg::ERR_W'(target)) - $signed(lsps_pkg::ERR_W'(cnt3_ff));

   // stage 5: direction, switch check and saturation
   assign dband_s   = $signed(lsps_pkg::ERR_W'(deadband_ff));
   assign move_up   = (err4_ff > dband_s);
   assign move_down = (err4_ff < -dband_s);
   assign err_abs   = move_up ? err4_ff : -err4_ff;
   assign mag       = err_abs[lsps_pkg::COUNT_W-1:0];

   always_comb begin
      dec_in.valid = v4_ff;
      dec_in.seek  = fl4_ff.seek;
      dec_in.sat   = (mag >= lsps_pkg::COUNT_W'(lsps_pkg::SPAN));
      dec_in.mag   = mag[lsps_pkg::OFF_W-1:0];
      if (fl4_ff.seek) begin
         if (fl4_ff.seek_high) begin
            dec_in.cmd = fl4_ff.high_sw ? lsps_pkg::CMD_LOAD_HIGH : lsps_pkg::CMD_UP;
         end else begin
            dec_in.cmd = fl4_ff.low_sw ? lsps_pkg::CMD_LOAD_LOW : lsps_pkg::CMD_DOWN;
         end
      end else if (move_up) begin
         dec_in.cmd = fl4_ff.high_sw ? lsps_pkg::CMD_LOAD_HIGH : lsps_pkg::CMD_UP;
      end else if (move_down) begin
         dec_in.cmd = fl4_ff.low_sw ? lsps_pkg::CMD_LOAD_LOW : lsps_pkg::CMD_DOWN;
      end else begin
         dec_in.cmd = lsps_pkg::CMD_STOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff   <= lsps_pkg::DEADBAND_RESET;
         min_drive_ff  <= lsps_pkg::MIN_DRIVE_RESET;
         max_drive_ff  <= lsps_pkg::MAX_DRIVE_RESET;
         seek_drive_ff <= lsps_pkg::SEEK_DRIVE_RESET;
         zero_high_ff  <= 1'b1;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         dec_ff        <= '0;
      end else begin
         deadband_ff   <= deadband_in;
         min_drive_ff  <= min_drive_in;
         max_drive_ff  <= max_drive_in;
         seek_drive_ff <= seek_drive_in;
         zero_high_ff  <= zero_high_in;
         v1_ff         <= req_accept;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         dec_ff        <= dec_in;
      end
      t1_ff     <= t1_in;
      cnt1_ff   <= req_encoder_count;
      lsw1_ff   <= req_low_switch_pressed;
      hsw1_ff   <= req_high_switch_pressed;
      fl2_ff    <= fl2_in;
      whole2_ff <= whole2_in;
      rem2_ff   <= rem2_in;
      cnt2_ff   <= cnt1_ff;
      fl3_ff    <= fl2_ff;
      off3_ff   <= off3_in;
      cnt3_ff   <= cnt2_ff;
      fl4_ff    <= fl3_ff;
      err4_ff   <= err4_in;
   end

   lsps_drive u_drive (
      .clock              (clock),
      .reset              (reset),
      .dec                (dec_ff),
      .min_drive          (min_drive_ff),
      .max_drive          (max_drive_ff),
      .seek_drive         (seek_drive_ff),
      .rsp_strobe         (rsp_strobe),
      .rsp_drive_up       (rsp_drive_up),
      .rsp_drive_down     (rsp_drive_down),
      .rsp_reload_counter (rsp_reload_counter),
      .rsp_reload_value   (rsp_reload_value),
      .rsp_motion_status  (rsp_motion_status)
   );

   // every accepted item comes out after the fixed latency
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##(lsps_pkg::LATENCY) rsp_strobe)
      else $error("accepted item lost");

   // no result without an item accepted the latency earlier
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, lsps_pkg::LATENCY))
      else $error("result without accepted item");

   // a counter reload always stops the motor
   a_reload_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_reload_counter) |->
         (rsp_motion_status == lsps_pkg::STATUS_STOP &&
          rsp_drive_up == '0 && rsp_drive_down == '0))
      else $error("reload while driving");

   // never drive both directions at once
   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_drive_up == '0 || rsp_drive_down == '0))
      else $error("both directions driven");

endmodule

/* tb/limit_switch_position_servo_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_switch_position_servo_test
// Self-checking bench for the limit switch position servo. A short table of
// hand-picked items (seek targets, switch handling, deadband edges, clamping)
// runs first, then bursts of random items under a series of register
// settings. Each result is checked against a table golden or in-bench model.
// ----------------------------------------------------------------------------
module limit_switch_position_servo_test;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 210;

   localparam longint LO_END = lsps_pkg::LOW_END_COUNT;
   localparam longint HI_END = lsps_pkg::HIGH_END_COUNT;
   localparam longint SPAN_L = HI_END - LO_END;

   typedef struct packed {
      logic [lsps_pkg::DRIVE_W-1:0]  drive_up;
      logic [lsps_pkg::DRIVE_W-1:0]  drive_down;
      logic                          reload;
      logic [lsps_pkg::COUNT_W-1:0]  reload_value;
      logic [lsps_pkg::STATUS_W-1:0] status;
   } servo_cmd_type;

   typedef struct {
      logic [lsps_pkg::TARGET_W-1:0] tgt;
      logic [lsps_pkg::COUNT_W-1:0]  count;
      logic                          low_sw;
      logic                          high_sw;
      logic                          has_golden;
      servo_cmd_type                 golden;
   } stim_row_type;

   // results that follow from the reset register values
   localparam servo_cmd_type GOLD_HOLD      = '0;
   localparam servo_cmd_type GOLD_SEEK_UP   =
      '{lsps_pkg::SEEK_DRIVE_RESET, '0, 1'b0, '0, lsps_pkg::STATUS_UP};
   localparam servo_cmd_type GOLD_SEEK_DOWN =
      '{'0, lsps_pkg::SEEK_DRIVE_RESET, 1'b0, '0, lsps_pkg::STATUS_DOWN};
   localparam servo_cmd_type GOLD_FULL_UP   =
      '{lsps_pkg::MAX_DRIVE_RESET, '0, 1'b0, '0, lsps_pkg::STATUS_UP};
   localparam servo_cmd_type GOLD_FULL_DOWN =
      '{'0, lsps_pkg::MAX_DRIVE_RESET, 1'b0, '0, lsps_pkg::STATUS_DOWN};
   localparam servo_cmd_type GOLD_LOAD_HIGH =
      '{'0, '0, 1'b1, lsps_pkg::COUNT_W'(lsps_pkg::HIGH_END_COUNT), lsps_pkg::STATUS_STOP};
   localparam servo_cmd_type GOLD_LOAD_LOW  =
      '{'0, '0, 1'b1, lsps_pkg::COUNT_W'(lsps_pkg::LOW_END_COUNT), lsps_pkg::STATUS_STOP};

   // with target 0 at the high end, target 125 maps to the middle of the span
   localparam logic [lsps_pkg::TARGET_W-1:0] MID_T =
      lsps_pkg::TARGET_W'(lsps_pkg::TARGET_FULL / 2);
   localparam logic [lsps_pkg::COUNT_W-1:0]  MID_COUNT =
      lsps_pkg::COUNT_W'(lsps_pkg::HIGH_END_COUNT - lsps_pkg::SPAN / 2);
   localparam logic [lsps_pkg::TARGET_W-1:0] T_FULL =
      lsps_pkg::TARGET_W'(lsps_pkg::TARGET_FULL);
   localparam logic [lsps_pkg::COUNT_W-1:0]  C_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [lsps_pkg::TARGET_W-1:0]    req_target_position = '0;
   logic [lsps_pkg::COUNT_W-1:0]     req_encoder_count = '0;
   logic                             req_low_switch_pressed = 1'b0;
   logic                             req_high_switch_pressed = 1'b0;
   logic                             rsp_strobe;
   logic [lsps_pkg::DRIVE_W-1:0]     rsp_drive_up;
   logic [lsps_pkg::DRIVE_W-1:0]     rsp_drive_down;
   logic                             rsp_reload_counter;
   logic [lsps_pkg::COUNT_W-1:0]     rsp_reload_value;
   logic [lsps_pkg::STATUS_W-1:0]    rsp_motion_status;
   logic                             csr_we = 1'b0;
   logic [lsps_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lsps_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // golden value travelling with the item on the request ports
   logic          row_has_golden = 1'b0;
   servo_cmd_type row_golden = '0;

   // register copies
   logic [lsps_pkg::DBAND_W-1:0] cfg_deadband;
   logic [lsps_pkg::DRIVE_W-1:0] cfg_min_drive;
   logic [lsps_pkg::DRIVE_W-1:0] cfg_max_drive;
   logic [lsps_pkg::DRIVE_W-1:0] cfg_seek_drive;
   logic                         cfg_zero_high;

   servo_cmd_type pending_cmds[$];
   int error_count = 0;
   int accepted_count = 0;
   int idle_cycles = 0;

   stim_row_type directed_rows [0:22] = '{
      '{8'd0,   16'd0,          1'b0, 1'b0, 1'b1, GOLD_SEEK_UP},
      '{8'd0,   C_MAX,          1'b1, 1'b0, 1'b1, GOLD_SEEK_UP},
      '{8'd0,   16'd12345,      1'b0, 1'b1, 1'b1, GOLD_LOAD_HIGH},
      '{T_FULL, C_MAX,          1'b0, 1'b0, 1'b1, GOLD_SEEK_DOWN},
      '{T_FULL, 16'd0,          1'b0, 1'b1, 1'b1, GOLD_SEEK_DOWN},
      '{T_FULL, 16'd30000,      1'b1, 1'b0, 1'b1, GOLD_LOAD_LOW},
      '{8'd255, 16'd29720,      1'b0, 1'b1, 1'b1, GOLD_SEEK_DOWN},
      '{8'd251, 16'd0,          1'b1, 1'b1, 1'b1, GOLD_LOAD_LOW},
      '{MID_T,  MID_COUNT,      1'b1, 1'b1, 1'b1, GOLD_HOLD},
      '{MID_T,  lsps_pkg::COUNT_W'(MID_COUNT - 5), 1'b0, 1'b0, 1'b1, GOLD_HOLD},
      '{MID_T,  lsps_pkg::COUNT_W'(MID_COUNT + 5), 1'b0, 1'b0, 1'b1, GOLD_HOLD},
      '{MID_T,  lsps_pkg::COUNT_W'(MID_COUNT - 6), 1'b0, 1'b0, 1'b0, GOLD_HOLD},
      '{MID_T,  lsps_pkg::COUNT_W'(MID_COUNT + 6), 1'b0, 1'b0, 1'b0, GOLD_HOLD},
      '{MID_T,  MID_COUNT - lsps_pkg::COUNT_W'(lsps_pkg::SPAN),
                1'b0, 1'b0, 1'b1, GOLD_FULL_UP},
      '{MID_T,  MID_COUNT - lsps_pkg::COUNT_W'(lsps_pkg::SPAN - 1),
                1'b0, 1'b0, 1'b0, GOLD_HOLD},
      '{MID_T,  16'd0,          1'b1, 1'b0, 1'b1, GOLD_FULL_UP},
      '{MID_T,  16'd0,          1'b0, 1'b1, 1'b1, GOLD_LOAD_HIGH},
      '{MID_T,  C_MAX,          1'b0, 1'b1, 1'b1, GOLD_FULL_DOWN},
      '{MID_T,  C_MAX,          1'b1, 1'b0, 1'b1, GOLD_LOAD_LOW},
      '{8'd1,   16'd30000,      1'b0, 1'b0, 1'b0, GOLD_HOLD},
      '{8'd249, 16'd29720,      1'b0, 1'b0, 1'b0, GOLD_HOLD},
      '{8'd128, 16'h5555,       1'b0, 1'b0, 1'b0, GOLD_HOLD},
      '{8'd127, 16'hAAAA,       1'b0, 1'b0, 1'b0, GOLD_HOLD}
   };

   limit_switch_position_servo uut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_target_position     (req_target_position),
      .req_encoder_count       (req_encoder_count),
      .req_low_switch_pressed  (req_low_switch_pressed),
      .req_high_switch_pressed (req_high_switch_pressed),
      .rsp_strobe              (rsp_strobe),
      .rsp_drive_up            (rsp_drive_up),
      .rsp_drive_down          (rsp_drive_down),
      .rsp_reload_counter      (rsp_reload_counter),
      .rsp_reload_value        (rsp_reload_value),
      .rsp_motion_status       (rsp_motion_status),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // encoder count that a target in 1..249 maps to
   function automatic longint mapped_count(input logic [lsps_pkg::TARGET_W-1:0] tgt);
      longint first_end;
      longint last_end;
      first_end = cfg_zero_high ? HI_END : LO_END;
      last_end  = cfg_zero_high ? LO_END : HI_END;
      return first_end + (longint'(tgt) * (last_end - first_end))
                         / longint'(lsps_pkg::TARGET_FULL);
   endfunction

   function automatic logic [lsps_pkg::DRIVE_W-1:0] proportional_drive(input longint mag);
      longint lo;
      longint hi;
      lo = longint'(cfg_min_drive);
      hi = longint'(cfg_max_drive);
      if (SPAN_L <= 0 || mag >= SPAN_L)
         return lsps_pkg::DRIVE_W'(hi);
      return lsps_pkg::DRIVE_W'(lo + (mag * (hi - lo)) / SPAN_L);
   endfunction

   function automatic servo_cmd_type predict_servo_cmd(
         input logic [lsps_pkg::TARGET_W-1:0] tgt,
         input logic [lsps_pkg::COUNT_W-1:0] count,
         input logic low_sw,
         input logic high_sw);
      servo_cmd_type cmd;
      logic [lsps_pkg::TARGET_W-1:0] t;
      logic seek_high;
      longint err;
      cmd = '0;
      t = (tgt > T_FULL) ? T_FULL : tgt;
      if (t == 0 || t == T_FULL) begin
         seek_high = (t == 0) ? cfg_zero_high : !cfg_zero_high;
         if (seek_high) begin
            if (high_sw) begin
               cmd.reload = 1'b1;
               cmd.reload_value = lsps_pkg::COUNT_W'(lsps_pkg::HIGH_END_COUNT);
            end else begin
               cmd.drive_up = cfg_seek_drive;
               cmd.status = lsps_pkg::STATUS_UP;
            end
         end else begin
            if (low_sw) begin
               cmd.reload = 1'b1;
               cmd.reload_value = lsps_pkg::COUNT_W'(lsps_pkg::LOW_END_COUNT);
            end else begin
               cmd.drive_down = cfg_seek_drive;
               cmd.status = lsps_pkg::STATUS_DOWN;
            end
         end
      end else begin
         err = mapped_count(t) - longint'(count);
         // switches only count in the direction of travel
         if (err > longint'(cfg_deadband)) begin
            if (high_sw) begin
               cmd.reload = 1'b1;
               cmd.reload_value = lsps_pkg::COUNT_W'(lsps_pkg::HIGH_END_COUNT);
            end else begin
               cmd.drive_up = proportional_drive(err);
               cmd.status = lsps_pkg::STATUS_UP;
            end
         end else if (-err > longint'(cfg_deadband)) begin
            if (low_sw) begin
               cmd.reload = 1'b1;
               cmd.reload_value = lsps_pkg::COUNT_W'(lsps_pkg::LOW_END_COUNT);
            end else begin
               cmd.drive_down = proportional_drive(-err);
               cmd.status = lsps_pkg::STATUS_DOWN;
            end
         end
      end
      return cmd;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_servo_cmd(input servo_cmd_type got, input servo_cmd_type want);
      if (got.drive_up !== want.drive_up)
         report_mismatch($sformatf("drive_up %0d, expected %0d", got.drive_up, want.drive_up));
      if (got.drive_down !== want.drive_down)
         report_mismatch($sformatf("drive_down %0d, expected %0d",
                                   got.drive_down, want.drive_down));
      if (got.reload !== want.reload)
         report_mismatch($sformatf("reload_counter %0b, expected %0b", got.reload, want.reload));
      if (got.reload_value !== want.reload_value)
         report_mismatch($sformatf("reload_value %0d, expected %0d",
                                   got.reload_value, want.reload_value));
      if (got.status !== want.status)
         report_mismatch($sformatf("motion_status %0d, expected %0d", got.status, want.status));
   endtask

   // register copies, expected results and the result checker
   always @(posedge clock) begin
      if (reset) begin
         cfg_deadband   <= lsps_pkg::DEADBAND_RESET;
         cfg_min_drive  <= lsps_pkg::MIN_DRIVE_RESET;
         cfg_max_drive  <= lsps_pkg::MAX_DRIVE_RESET;
         cfg_seek_drive <= lsps_pkg::SEEK_DRIVE_RESET;
         cfg_zero_high  <= 1'b1;
      end else begin
         if (csr_we) begin
            case (csr_index)
               lsps_pkg::REG_DEADBAND:   cfg_deadband   <= csr_wdata[lsps_pkg::DBAND_W-1:0];
               lsps_pkg::REG_MIN_DRIVE:  cfg_min_drive  <= csr_wdata[lsps_pkg::DRIVE_W-1:0];
               lsps_pkg::REG_MAX_DRIVE:  cfg_max_drive  <= csr_wdata[lsps_pkg::DRIVE_W-1:0];
               lsps_pkg::REG_SEEK_DRIVE: cfg_seek_drive <= csr_wdata[lsps_pkg::DRIVE_W-1:0];
               lsps_pkg::REG_ZERO_HIGH:  cfg_zero_high  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (pending_cmds.size() == 0)
               report_mismatch("result with no item outstanding");
            else
               check_servo_cmd('{rsp_drive_up, rsp_drive_down, rsp_reload_counter,
                                 rsp_reload_value, rsp_motion_status},
                               pending_cmds.pop_front());
         end
         if (start && !busy) begin
            accepted_count++;
            if (row_has_golden)
               pending_cmds.push_back(row_golden);
            else
               pending_cmds.push_back(predict_servo_cmd(req_target_position,
                                                        req_encoder_count,
                                                        req_low_switch_pressed,
                                                        req_high_switch_pressed));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_item(input logic [lsps_pkg::TARGET_W-1:0] tgt,
                            input logic [lsps_pkg::COUNT_W-1:0] count,
                            input logic low_sw, input logic high_sw,
                            input logic has_golden, input servo_cmd_type golden);
      req_target_position     <= tgt;
      req_encoder_count       <= count;
      req_low_switch_pressed  <= low_sw;
      req_high_switch_pressed <= high_sw;
      row_has_golden          <= has_golden;
      row_golden              <= golden;
      start                   <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic random_item(output logic [lsps_pkg::TARGET_W-1:0] tgt,
                              output logic [lsps_pkg::COUNT_W-1:0] count,
                              output logic low_sw, output logic high_sw);
      int sel;
      int base;
      int mag;
      int c;
      sel = int'($urandom_range(0, 99));
      if (sel < 8)
         tgt = '0;
      else if (sel < 16)
         tgt = T_FULL;
      else if (sel < 20)
         tgt = lsps_pkg::TARGET_W'($urandom_range(lsps_pkg::TARGET_FULL + 1, 255));
      else
         tgt = lsps_pkg::TARGET_W'($urandom_range(1, lsps_pkg::TARGET_FULL - 1));
      base = int'(mapped_count(tgt));
      sel = int'($urandom_range(0, 99));
      if (sel < 35) begin
         // right around the deadband edge
         mag = int'(cfg_deadband) + int'($urandom_range(0, 4)) - 2;
         if (mag < 0)
            mag = 0;
         c = $urandom_range(0, 1) ? base + mag : base - mag;
      end else if (sel < 70) begin
         c = base + int'($urandom_range(0, 2 * lsps_pkg::SPAN + 200))
                  - int'(lsps_pkg::SPAN + 100);
      end else if (sel < 85) begin
         c = int'(lsps_pkg::LOW_END_COUNT) - 20
           + int'($urandom_range(0, lsps_pkg::SPAN + 40));
      end else begin
         c = int'($urandom_range(0, 65535));
      end
      if (c < 0)
         c = 0;
      if (c > 65535)
         c = 65535;
      count   = lsps_pkg::COUNT_W'(c);
      low_sw  = ($urandom_range(0, 3) == 0);
      high_sw = ($urandom_range(0, 3) == 0);
   endtask

   task automatic write_reg(input logic [lsps_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [lsps_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [lsps_pkg::CSR_DATA_W-1:0] band,
                               input logic [lsps_pkg::CSR_DATA_W-1:0] lo_drive,
                               input logic [lsps_pkg::CSR_DATA_W-1:0] hi_drive,
                               input logic [lsps_pkg::CSR_DATA_W-1:0] seek,
                               input logic [lsps_pkg::CSR_DATA_W-1:0] zero_high);
      write_reg(lsps_pkg::REG_DEADBAND, band);
      write_reg(lsps_pkg::REG_MIN_DRIVE, lo_drive);
      write_reg(lsps_pkg::REG_MAX_DRIVE, hi_drive);
      write_reg(lsps_pkg::REG_SEEK_DRIVE, seek);
      write_reg(lsps_pkg::REG_ZERO_HIGH, zero_high);
      csr_we <= 1'b0;
   endtask

   // the pipeline must be empty before the registers change
   task automatic wait_drained();
      @(posedge clock);
      while (pending_cmds.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [lsps_pkg::TARGET_W-1:0] tgt;
      logic [lsps_pkg::COUNT_W-1:0]  count;
      logic                          low_sw;
      logic                          high_sw;
      int                            sent;
      int                            burst_len;
      int                            k;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].tgt, directed_rows[i].count, directed_rows[i].low_sw,
                   directed_rows[i].high_sw, directed_rows[i].has_golden,
                   directed_rows[i].golden);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            start <= 1'b0;
            wait_drained();
            case (phase)
               1: program_regs('0, '0, '1, '1, '0);
               // deadband write carries junk in the upper bits; drive order reversed
               2: program_regs('1, '1, '0, '0, 10'h3FF);
               3: program_regs('0, '1, '1, 10'd1, 10'h2);
               4: begin
                  // unmapped indexes must not disturb anything
                  for (int i = int'(lsps_pkg::REG_ZERO_HIGH) + 1;
                       i < 2 ** lsps_pkg::CSR_INDEX_W; i++)
                     write_reg(lsps_pkg::CSR_INDEX_W'(i), lsps_pkg::CSR_DATA_W'($urandom));
                  program_regs(lsps_pkg::CSR_DATA_W'($urandom_range(0, 40)),
                               lsps_pkg::CSR_DATA_W'($urandom),
                               lsps_pkg::CSR_DATA_W'($urandom),
                               lsps_pkg::CSR_DATA_W'($urandom),
                               lsps_pkg::CSR_DATA_W'($urandom));
               end
               default: program_regs($urandom_range(0, 1) ?
                                        lsps_pkg::CSR_DATA_W'($urandom_range(0, 40)) :
                                        lsps_pkg::CSR_DATA_W'($urandom),
                                     lsps_pkg::CSR_DATA_W'($urandom),
                                     lsps_pkg::CSR_DATA_W'($urandom),
                                     lsps_pkg::CSR_DATA_W'($urandom),
                                     lsps_pkg::CSR_DATA_W'($urandom));
            endcase
         end
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst_len = int'($urandom_range(1, 40));
            for (k = 0; k < burst_len && sent < ITEMS_PER_PHASE; k++) begin
               random_item(tgt, count, low_sw, high_sw);
               send_item(tgt, count, low_sw, high_sw, 1'b0, GOLD_HOLD);
               sent++;
            end
            // sometimes run straight into the next burst
            if ($urandom_range(0, 3) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
      end

      start <= 1'b0;
      wait_drained();
      repeat (2 * lsps_pkg::LATENCY) @(posedge clock);
      if (pending_cmds.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_cmds.size()));
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
rtl/lsps_pkg.sv
rtl/lsps_drive.sv
rtl/limit_switch_position_servo.sv
tb/limit_switch_position_servo_test.sv
